FILE: hw/rtl/image_column_additive_synth_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the image column synth core
// clocked, reset-qualified property checks
// ----------------------------------------------------------------------------
`ifndef IMAGE_COLUMN_ADDITIVE_SYNTH_CORE_MACROS_SVH
`define IMAGE_COLUMN_ADDITIVE_SYNTH_CORE_MACROS_SVH

// plain property, disabled while in reset
`define ICAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, disabled while in reset
`define ICAS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/icas_pkg.sv
// ----------------------------------------------------------------------------
// icas_pkg
// shared types and constants of the image column additive synth core
// ----------------------------------------------------------------------------
package icas_pkg;

    localparam int DEF_MAX_ROWS        = 2048;
    localparam int DEF_SAMPLE_RATE_HZ  = 44100;
    localparam int DEF_SINE_TABLE_SIZE = 4096;

    localparam int HEIGHT_W   = 12;
    localparam int SPC_W      = 16;
    localparam int TOP_W      = 15;
    localparam int THR_W      = 8;
    localparam int ROW_W      = 11;
    localparam int CH_W       = 8;
    localparam int LEVEL_W    = 10;
    localparam int SAMPLE_W   = 16;
    localparam int SINE_W     = 16;
    localparam int AMP_W      = 20;
    localparam int DIVISOR_W  = 13;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THR    = 2'd3;

    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 12'd2048;
    localparam logic [SPC_W-1:0]    RST_SPC    = 16'd8820;
    localparam logic [TOP_W-1:0]    RST_TOP    = 15'd22000;
    localparam logic [THR_W-1:0]    RST_THR    = 8'd10;

    localparam int                LEVEL_COUNT   = 766;
    localparam longint unsigned   HALF_PI_Q30   = 64'd1686629713;
    localparam longint unsigned   AMP_START_Q32 = 64'd2415238;
    localparam longint unsigned   AMP_STEP_Q24  = 64'd16992362;

    typedef enum logic [1:0] {
        K_START,
        K_LOAD,
        K_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [SPC_W-1:0]    spc;
        logic [TOP_W-1:0]    top;
        logic [THR_W-1:0]    thr;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_FREQ,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_SAMPLE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: hw/rtl/icas_front.sv
// ----------------------------------------------------------------------------
// icas_front
// takes input words, sorts them by command and queues the useful ones
// ----------------------------------------------------------------------------
module icas_front import icas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [CH_W-1:0]    i_red,
    input  logic [CH_W-1:0]    i_green,
    input  logic [CH_W-1:0]    i_blue,
    input  logic [THR_W-1:0]   i_thr,
    output t_item              o_item,
    output logic               o_item_valid,
    input  logic               i_pop
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_item           r_mem [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr;
    logic [QW-1:0]   r_rd_ptr;
    logic [QW:0]     r_fill;
    logic            w_keep;
    logic            w_queue;
    logic            w_push;
    t_item           w_item;

    assign w_keep = (i_red > i_thr) || ((i_green > i_thr) && (i_blue > i_thr));

    always_comb begin
        w_item.row   = i_row;
        w_item.level = {2'b00, i_red} + {2'b00, i_green} + {2'b00, i_blue};
        w_item.kind  = K_START;
        w_queue      = 1'b0;
        unique case (i_cmd)
            CMD_START: begin
                w_item.kind = K_START;
                w_queue     = 1'b1;
            end
            CMD_LOAD: begin
                w_item.kind = K_LOAD;
                w_queue     = w_keep;
            end
            CMD_SAMPLE: begin
                w_item.kind = K_SAMPLE;
                w_queue     = 1'b1;
            end
            default: begin
                w_queue = 1'b0;
            end
        endcase
    end

    assign o_ready      = (r_fill != (QW+1)'(QUEUE_DEPTH));
    assign w_push       = i_valid && o_ready && w_queue;
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= r_fill + (QW+1)'(w_push) - (QW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

FILE: hw/rtl/icas_div.sv
// ----------------------------------------------------------------------------
// icas_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module icas_div import icas_pkg::*; #(
    parameter int DW = 32,
    parameter int VW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output t_div_stat     o_stat,
    output logic [DW-1:0] o_quotient
);

    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   w_trial;
    logic          w_ge;
    logic [VW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? VW'(w_trial - {1'b0, r_den}) : w_trial[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: hw/rtl/icas_back.sv
// ----------------------------------------------------------------------------
// icas_back
// oscillator store, sample walk pipeline and result register
// ----------------------------------------------------------------------------
`include "image_column_additive_synth_core_macros.svh"

module icas_back import icas_pkg::*; #(
    parameter int MAX_ROWS        = DEF_MAX_ROWS,
    parameter int SAMPLE_RATE_HZ  = DEF_SAMPLE_RATE_HZ,
    parameter int SINE_TABLE_SIZE = DEF_SINE_TABLE_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_item               i_item,
    input  logic                i_item_valid,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_out_sample,
    output logic                o_out_last,
    output logic                o_out_clip
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_ROWS + 1);
    localparam int PW  = $clog2(SAMPLE_RATE_HZ);
    localparam int IW  = $clog2(SINE_TABLE_SIZE);
    localparam int LW  = $clog2(LEVEL_COUNT);
    localparam longint unsigned RECIP =
        (64'(SINE_TABLE_SIZE) << PW) / 64'(SAMPLE_RATE_HZ);
    localparam int MW      = $clog2(RECIP + 1);
    localparam int RW      = PW + IW + 2;
    localparam int PROD_W  = SINE_W + AMP_W + 1;
    localparam int ACC_W   = PROD_W + CW;
    localparam int SC_W    = ACC_W + 15;
    localparam int T_W     = SC_W - 31;
    localparam int NUM_W   = ROW_W + 1 + TOP_W + 1;
    localparam int DW      = (T_W > NUM_W) ? T_W : NUM_W;
    localparam int VW      = (CW > DIVISOR_W) ? CW : DIVISOR_W;
    localparam int FW      = (TOP_W > PW + 1) ? TOP_W : PW + 1;
    localparam int FOLD_STEPS = (1 << TOP_W) / SAMPLE_RATE_HZ + 1;

    // taylor series of one quarter turn in q30, rounded to q15
    function automatic longint quarter_sine(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        term = ((term * x2) >> 30) / 6;   acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 20;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 42;  acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 72;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 110; acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 156; acc = acc + longint'(term);
        if (acc < 0) acc = 0;
        acc = (acc + 16384) >>> 15;
        if (acc > 32767) acc = 32767;
        return acc;
    endfunction

    function automatic logic signed [SINE_W-1:0] sine_entry(input int i);
        longint unsigned ii;
        longint unsigned quad;
        longint unsigned rmd;
        longint unsigned x;
        longint          s;
        ii   = 64'(i);
        quad = (4 * ii) / SINE_TABLE_SIZE;
        rmd  = 4 * ii - quad * SINE_TABLE_SIZE;
        x    = rmd * HALF_PI_Q30 / SINE_TABLE_SIZE;
        if (quad[0]) s = quarter_sine(HALF_PI_Q30 - x);
        else         s = quarter_sine(x);
        if (quad >= 2) s = -s;
        return SINE_W'(s);
    endfunction

    // level n amplitude, q4.16
    function automatic logic [AMP_W-1:0] amp_entry(input int n);
        longint unsigned v;
        int              k;
        v = AMP_START_Q32;
        for (k = 0; k < n; k++) begin
            v = (v * AMP_STEP_Q24 + (64'd1 << 23)) >> 24;
        end
        return AMP_W'((v + 64'd32768) >> 16);
    endfunction

    logic signed [SINE_W-1:0] w_sine_rom [SINE_TABLE_SIZE];
    logic [AMP_W-1:0]         w_amp_rom  [LEVEL_COUNT];

    for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_sine
        assign w_sine_rom[gi] = sine_entry(gi);
    end
    for (genvar ga = 0; ga < LEVEL_COUNT; ga++) begin : g_amp
        assign w_amp_rom[ga] = amp_entry(ga);
    end

    // oscillator store
    logic [PW-1:0]      r_freq_mem  [MAX_ROWS];
    logic [LEVEL_W-1:0] r_level_mem [MAX_ROWS];
    logic [PW:0]        r_phase_mem [MAX_ROWS];
    logic [PW-1:0]      r_rd_freq;
    logic [LEVEL_W-1:0] r_rd_level;
    logic [PW:0]        r_rd_phase;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [SPC_W-1:0]    r_pos, n_pos;
    logic                r_epoch, n_epoch;
    logic [LEVEL_W-1:0]  r_level;
    logic signed [ACC_W-1:0] r_acc;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                r_out_last, n_out_last;
    logic                r_out_clip, n_out_clip;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]       r_a1;
    logic [PW-1:0]       r_ph2;
    logic [PW+MW-1:0]    r_prod2;
    logic [LW-1:0]       r_lvl2;
    logic signed [SINE_W-1:0] r_sine3;
    logic [AMP_W-1:0]    r_amp3;
    logic signed [PROD_W-1:0] r_prod4;

    logic                w_issue;
    logic                w_acc_clr;
    logic                w_load_we;
    logic                w_div_start;
    logic [DW-1:0]       w_div_dividend;
    logic [VW-1:0]       w_div_divisor;
    t_div_stat           w_div_stat;
    logic [DW-1:0]       w_div_quo;

    logic [NUM_W-1:0]    w_num;
    logic [TOP_W-1:0]    w_freq;
    logic [FW-1:0]       w_fold;
    logic                w_last;
    logic [ACC_W-1:0]    w_mag;
    logic [SC_W-1:0]     w_scaled;
    logic [T_W-1:0]      w_t;
    logic                w_neg;

    logic [PW-1:0]       w_ph;
    logic [PW:0]         w_sum_ph;
    logic [PW-1:0]       w_nxt_ph;
    logic [MW-1:0]       w_q0;
    logic [RW-1:0]       w_rem;
    logic [MW-1:0]       w_q1;
    logic [IW-1:0]       w_sidx;

    icas_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    // frequency from the row, folded below the sample rate
    always_comb begin
        w_num = NUM_W'({1'b0, i_item.row} + (ROW_W+1)'(1)) * NUM_W'(i_cfg.top)
              + NUM_W'(i_cfg.height);
        if (w_div_quo >= DW'(i_cfg.top)) w_freq = '0;
        else w_freq = i_cfg.top - w_div_quo[TOP_W-1:0];
        w_fold = FW'(w_freq);
        for (int s = 0; s < FOLD_STEPS; s++) begin
            if (w_fold >= FW'(SAMPLE_RATE_HZ)) w_fold = w_fold - FW'(SAMPLE_RATE_HZ);
        end
    end

    // averaging: |sum| * 32767 / 2^31, later divided by the count
    always_comb begin
        w_neg    = r_acc[ACC_W-1];
        w_mag    = w_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        w_scaled = {w_mag, 15'd0} - SC_W'(w_mag);
        w_t      = w_scaled[SC_W-1:31];
        w_last   = (({1'b0, r_pos} + (SPC_W+1)'(1)) >= {1'b0, i_cfg.spc});
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        n_pos          = r_pos;
        n_epoch        = r_epoch;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_sample   = r_out_sample;
        n_out_last     = r_out_last;
        n_out_clip     = r_out_clip;
        o_pop          = 1'b0;
        w_issue        = 1'b0;
        w_acc_clr      = 1'b0;
        w_load_we      = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    unique case (i_item.kind)
                        K_START: begin
                            o_pop   = 1'b1;
                            n_count = '0;
                            n_pos   = '0;
                        end
                        K_LOAD: begin
                            o_pop = 1'b1;
                            if (r_count < CW'(MAX_ROWS)) begin
                                w_div_start    = 1'b1;
                                w_div_dividend = DW'(w_num);
                                w_div_divisor  = VW'(i_cfg.height) + VW'(1);
                                n_state        = ST_DIV_FREQ;
                            end
                        end
                        K_SAMPLE: begin
                            if (!r_out_valid) begin
                                o_pop = 1'b1;
                                if (r_count == '0) begin
                                    n_out_valid  = 1'b1;
                                    n_out_sample = '0;
                                    n_out_clip   = 1'b0;
                                    n_out_last   = w_last;
                                    if (w_last) begin
                                        n_pos   = '0;
                                        n_epoch = !r_epoch;
                                    end else begin
                                        n_pos = r_pos + 1'b1;
                                    end
                                end else begin
                                    n_idx     = '0;
                                    w_acc_clr = 1'b1;
                                    n_state   = ST_WALK;
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV_FREQ: begin
                if (w_div_stat.done) begin
                    w_load_we = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_WALK: begin
                w_issue = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx == r_count - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(r_v1 || r_v2 || r_v3 || r_v4)) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = DW'(w_t);
                    w_div_divisor  = VW'(r_count);
                    n_state        = ST_DIV_SAMPLE;
                end
            end
            ST_DIV_SAMPLE: begin
                if (w_div_stat.done) begin
                    n_out_valid = 1'b1;
                    n_out_last  = w_last;
                    n_out_clip  = 1'b0;
                    if (!w_neg) begin
                        if (w_div_quo > DW'(32767)) begin
                            n_out_sample = 16'h7FFF;
                            n_out_clip   = 1'b1;
                        end else begin
                            n_out_sample = w_div_quo[SAMPLE_W-1:0];
                        end
                    end else begin
                        if (w_div_quo > DW'(32768)) begin
                            n_out_sample = 16'h8000;
                            n_out_clip   = 1'b1;
                        end else begin
                            n_out_sample = -w_div_quo[SAMPLE_W-1:0];
                        end
                    end
                    if (w_last) begin
                        n_pos   = '0;
                        n_epoch = !r_epoch;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_epoch     <= 1'b0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
            r_epoch     <= n_epoch;
            r_out_valid <= n_out_valid;
            r_v1        <= w_issue;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        r_out_clip   <= n_out_clip;
        if (o_pop && (i_item.kind == K_LOAD)) begin
            r_level <= i_item.level;
        end
    end

    // stage 1: stale epoch reads as phase zero, advance and write back
    always_comb begin
        w_ph     = (r_rd_phase[PW] == r_epoch) ? r_rd_phase[PW-1:0] : '0;
        w_sum_ph = {1'b0, w_ph} + {1'b0, r_rd_freq};
        if (w_sum_ph >= (PW+1)'(SAMPLE_RATE_HZ)) begin
            w_nxt_ph = PW'(w_sum_ph - (PW+1)'(SAMPLE_RATE_HZ));
        end else begin
            w_nxt_ph = w_sum_ph[PW-1:0];
        end
    end

    // stage 2: table index by reciprocal multiply plus one correction
    always_comb begin
        w_q0  = r_prod2[PW+MW-1:PW];
        w_rem = RW'(r_ph2) * RW'(SINE_TABLE_SIZE) - RW'(w_q0) * RW'(SAMPLE_RATE_HZ);
        w_q1  = (w_rem >= RW'(SAMPLE_RATE_HZ)) ? w_q0 + 1'b1 : w_q0;
        w_sidx = (w_q1 >= MW'(SINE_TABLE_SIZE)) ? IW'(SINE_TABLE_SIZE - 1) : IW'(w_q1);
    end

    always_ff @(posedge i_clk) begin
        r_rd_freq  <= r_freq_mem[r_idx[AW-1:0]];
        r_rd_level <= r_level_mem[r_idx[AW-1:0]];
        r_rd_phase <= r_phase_mem[r_idx[AW-1:0]];
        if (w_load_we) begin
            r_freq_mem[r_count[AW-1:0]]  <= PW'(w_fold);
            r_level_mem[r_count[AW-1:0]] <= r_level;
            r_phase_mem[r_count[AW-1:0]] <= {r_epoch, PW'(0)};
        end else if (r_v1) begin
            r_phase_mem[r_a1] <= {r_epoch, w_nxt_ph};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1    <= r_idx[AW-1:0];
        r_ph2   <= w_ph;
        r_prod2 <= (PW+MW)'(w_ph) * (PW+MW)'(RECIP);
        r_lvl2  <= (r_rd_level < LEVEL_W'(LEVEL_COUNT)) ? LW'(r_rd_level)
                                                        : LW'(LEVEL_COUNT - 1);
        r_sine3 <= w_sine_rom[w_sidx];
        r_amp3  <= w_amp_rom[r_lvl2];
        r_prod4 <= PROD_W'(r_sine3) * $signed({1'b0, r_amp3});
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (r_v4) begin
            r_acc <= r_acc + ACC_W'(r_prod4);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;
    assign o_out_clip   = r_out_clip;

    `ICAS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_ROWS), "oscillator count overflow")
    `ICAS_ASSERT_IMPL(a_div_free, i_clk, i_rst_n, w_div_start, !w_div_stat.busy, "divider restarted while busy")
    `ICAS_ASSERT_IMPL(a_idle_drained, i_clk, i_rst_n, r_state == ST_IDLE, !(r_v1 || r_v2 || r_v3 || r_v4), "walk pipeline busy in idle")
    `ICAS_ASSERT_IMPL(a_done_owner, i_clk, i_rst_n, w_div_stat.done, (r_state == ST_DIV_FREQ) || (r_state == ST_DIV_SAMPLE), "divider result with no waiting state")

endmodule

FILE: hw/rtl/image_column_additive_synth_core.sv
// ----------------------------------------------------------------------------
// image_column_additive_synth_core: additive sine synthesis of one image column
// pixel load: bound by the serial divider
// sample: one store read per cycle over the oscillators, then the serial divide of the
// sum by the count; one word at a time in the back end
// synchronous active-low reset: registers to defaults, count and position to zero
// ----------------------------------------------------------------------------
module image_column_additive_synth_core import icas_pkg::*; #(
    parameter int MAX_ROWS        = DEF_MAX_ROWS,
    parameter int SAMPLE_RATE_HZ  = DEF_SAMPLE_RATE_HZ,
    parameter int SINE_TABLE_SIZE = DEF_SINE_TABLE_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // row[10:0], red, green, blue, zero pad
    input  logic [CMD_W-1:0]      s_axis_tuser,  // command
    // result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata,  // sample
    output logic                  m_axis_tlast,
    output logic [0:0]            m_axis_tuser,  // clipped
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_pop;
    logic  w_out_clip;

    // registers always writable; user writes only while core is quiet, not enforced
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height <= RST_HEIGHT;
            r_cfg.spc    <= RST_SPC;
            r_cfg.top    <= RST_TOP;
            r_cfg.thr    <= RST_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HEIGHT: r_cfg.height <= i_cfg_data[HEIGHT_W-1:0];
                REG_SPC:    r_cfg.spc    <= i_cfg_data[SPC_W-1:0];
                REG_TOP:    r_cfg.top    <= i_cfg_data[TOP_W-1:0];
                REG_THR:    r_cfg.thr    <= i_cfg_data[THR_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // front end: classify and queue, dropping dim pixels and unused commands
    icas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_row        (s_axis_tdata[10:0]),
        .i_red        (s_axis_tdata[18:11]),
        .i_green      (s_axis_tdata[26:19]),
        .i_blue       (s_axis_tdata[34:27]),
        .i_thr        (r_cfg.thr),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_pop        (w_pop)
    );

    // back end: oscillator store, walk pipeline, divider and output register
    icas_back #(
        .MAX_ROWS        (MAX_ROWS),
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_sample (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_clip   (w_out_clip)
    );

    assign m_axis_tuser[0] = w_out_clip;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for image_column_additive_synth_core
// drives pixel, start and sample words under random idling on both sides,
// predicts every sample word with an internal model of the oscillator bank
// and checks sample, last and clipped on each result word
// ----------------------------------------------------------------------------
module testbench;
    import icas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 NUM_ROWS   = DEF_MAX_ROWS;
    localparam int                 RATE       = DEF_SAMPLE_RATE_HZ;
    localparam int                 SINE_SIZE  = DEF_SINE_TABLE_SIZE;
    localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
    localparam int                 DENSE_ROWS = 40;
    localparam int                 SETTLE_CYC = 2300;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                clipped;
    } t_sample_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;   // row, red, green, blue, zero pad
    logic [CMD_W-1:0]      s_axis_tuser = CMD_START; // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;        // sample
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;        // clipped
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_HEIGHT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    image_column_additive_synth_core dut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // model of the oscillator bank
    // ------------------------------------------------------------------
    int                  sine_lut [SINE_SIZE];
    int unsigned         amp_lut [LEVEL_COUNT];
    logic [HEIGHT_W-1:0] cfg_height;
    logic [SPC_W-1:0]    cfg_spc;
    logic [TOP_W-1:0]    cfg_top;
    logic [THR_W-1:0]    cfg_thr;
    int unsigned         bank_freq [NUM_ROWS];
    int unsigned         bank_level [NUM_ROWS];
    int unsigned         bank_phase [NUM_ROWS];
    int unsigned         bank_count;
    int unsigned         column_pos;

    t_sample_word        pending_samples [$];
    int                  error_count = 0;
    int                  sent_items = 0;
    int                  sender_idle_pct = 0;
    int                  sink_stall_pct = 0;

    // taylor series of one quarter turn, result in q15
    function automatic int quarter_wave(longint unsigned x);
        longint unsigned x2, term;
        longint          acc;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 16384) >>> 15;
        if (acc > 32767) acc = 32767;
        return int'(acc);
    endfunction

    task automatic build_luts();
        longint unsigned v, quad, rem, x;
        int              s;
        v = AMP_START_Q32;
        for (int i = 0; i < SINE_SIZE; i++) begin
            quad = (4 * i) / SINE_SIZE;
            rem = 4 * i - quad * SINE_SIZE;
            x = rem * HALF_PI_Q30 / SINE_SIZE;
            s = quad[0] ? quarter_wave(HALF_PI_Q30 - x) : quarter_wave(x);
            sine_lut[i] = (quad >= 2) ? -s : s;
        end
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            amp_lut[i] = int'((v + 32768) >> 16);
            v = (v * AMP_STEP_Q24 + (64'd1 << 23)) >> 24;
        end
    endtask

    // works out the effect of one accepted word, queues the sample if any
    task automatic synth_predict(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                                 logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                 logic [CH_W-1:0] b);
        longint unsigned q, mag, m;
        longint          sum;
        int unsigned     ph, idx;
        t_sample_word    w;
        case (cmd)
            CMD_START: begin
                bank_count = 0;
                column_pos = 0;
            end
            CMD_LOAD: begin
                if ((r > cfg_thr || (g > cfg_thr && b > cfg_thr)) && bank_count < NUM_ROWS) begin
                    q = ((longint'(row) + 1) * cfg_top + cfg_height) / (longint'(cfg_height) + 1);
                    bank_freq[bank_count] = (q >= cfg_top) ? 0 : cfg_top - int'(q);
                    bank_level[bank_count] = r + g + b;
                    bank_phase[bank_count] = 0;
                    bank_count++;
                end
            end
            CMD_SAMPLE: begin
                sum = 0;
                w.clipped = 1'b0;
                w.sample = '0;
                for (int i = 0; i < bank_count; i++) begin
                    ph = bank_phase[i] % RATE;
                    idx = (longint'(ph) * SINE_SIZE) / RATE;
                    sum += longint'(sine_lut[idx]) * longint'(amp_lut[bank_level[i]]);
                    ph += bank_freq[i] % RATE;
                    if (ph >= RATE) ph -= RATE;
                    bank_phase[i] = ph;
                end
                if (bank_count > 0) begin
                    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
                    m = (mag * 32767) / (longint'(bank_count) << 31);
                    if (sum >= 0) begin
                        if (m > 32767) begin m = 32767; w.clipped = 1'b1; end
                        w.sample = m[15:0];
                    end else begin
                        if (m > 32768) begin m = 32768; w.clipped = 1'b1; end
                        w.sample = -m[15:0];
                    end
                end
                w.last = (column_pos + 1 >= cfg_spc);
                if (w.last) begin
                    column_pos = 0;
                    foreach (bank_phase[i]) bank_phase[i] = 0;
                end else begin
                    column_pos = (column_pos + 1) & 16'hFFFF;
                end
                pending_samples.push_back(w);
            end
            default: ;  // unused command, nothing happens
        endcase
    endtask

    // ------------------------------------------------------------------
    // result checker: compares each accepted word with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sample_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result word sample=%h last=%b clipped=%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end else begin
                w = pending_samples.pop_front();
                if (m_axis_tdata !== w.sample) begin
                    $display("%0t: sample expected %h actual %h", $time, w.sample, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== w.last) begin
                    $display("%0t: last expected %b actual %b", $time, w.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser[0] !== w.clipped) begin
                    $display("%0t: clipped expected %b actual %b", $time, w.clipped,
                             m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // sends one word, holding tvalid high across back-to-back words
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                             logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'd0, b, g, r, row};
        do @(posedge i_clk); while (!s_axis_tready);
        synth_predict(cmd, row, r, g, b);
        sent_items++;
    endtask

    // waits until all samples are in and the core has had time to finish a load
    task automatic drain_core();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
            REG_SPC:    cfg_spc = value[SPC_W-1:0];
            REG_TOP:    cfg_top = value[TOP_W-1:0];
            default:    cfg_thr = value[THR_W-1:0];
        endcase
    endtask

    task automatic set_regs(int h, int spc, int top, int thr);
        drain_core();
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_SPC, CFG_DATA_W'(spc));
        write_reg(REG_TOP, CFG_DATA_W'(top));
        write_reg(REG_THR, CFG_DATA_W'(thr));
    endtask

    task automatic set_idling(int sender, int sink);
        sender_idle_pct = sender;
        sink_stall_pct = sink;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        set_idling(0, 0);
        // empty column right after reset gives a zero sample
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        send_word(CMD_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 8'hFF);
        // threshold edge: exactly at the level is dropped
        send_word(CMD_LOAD, 5, 10, 10, 10);
        send_word(CMD_LOAD, 5, 10, 11, 11);
        send_word(CMD_LOAD, 0, 11, 0, 0);
        send_word(CMD_LOAD, 11'h7FF, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        // pixel loaded mid column starts at phase zero
        send_word(CMD_LOAD, 1000, 0, 200, 200);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        send_word(CMD_START, 0, 0, 0, 0);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        // zero height, one sample per column, top at its widest, threshold at zero
        set_regs(0, 0, 16'h7FFF, 0);
        send_word(CMD_LOAD, 0, 0, 0, 0);
        send_word(CMD_LOAD, 3, 1, 0, 0);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        send_word(CMD_SAMPLE, 0, 0, 0, 0);
        // rows past the height with the threshold at 255: both pixels are dropped
        set_regs(1, 3, 1, 255);
        send_word(CMD_START, 0, 0, 0, 0);
        send_word(CMD_LOAD, 11'h7FF, 0, 255, 255);
        send_word(CMD_LOAD, 0, 8'hFF, 0, 0);
        set_regs(4095, 65535, 22050, 0);
        send_word(CMD_START, 0, 0, 0, 0);
        repeat (3) send_word(CMD_LOAD, 40, 255, 255, 255);
        repeat (4) send_word(CMD_SAMPLE, 0, 0, 0, 0);
    endtask

    // a column with many bright pixels, back to back
    task automatic test_dense_column();
        set_regs(2048, 2, 22000, 10);
        set_idling(0, 0);
        send_word(CMD_START, 0, 0, 0, 0);
        for (int i = 0; i < DENSE_ROWS; i++)
            send_word(CMD_LOAD, ROW_W'(i * 51), CH_W'($urandom_range(11, 255)),
                      CH_W'($urandom), CH_W'($urandom));
        repeat (2) send_word(CMD_SAMPLE, 0, 0, 0, 0);
    endtask

    function automatic logic [CH_W-1:0] rand_level();
        // mostly near the threshold, sometimes anywhere
        if ($urandom_range(3) == 0) return CH_W'($urandom);
        return 8'(int'(cfg_thr) + $urandom_range(0, 4) - 2);
    endfunction

    task automatic run_random(int n_items);
        int stop_at;
        stop_at = sent_items + n_items;
        while (sent_items < stop_at) begin
            if ($urandom_range(99) < 85) begin
                send_word(CMD_START, ROW_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                          CH_W'($urandom));
                repeat ($urandom_range(0, 10))
                    send_word(CMD_LOAD, ROW_W'($urandom), rand_level(), rand_level(),
                              rand_level());
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(9) == 0)
                        send_word(CMD_LOAD, ROW_W'($urandom), CH_W'($urandom),
                                  CH_W'($urandom), CH_W'($urandom));
                    send_word(CMD_SAMPLE, ROW_W'($urandom), CH_W'($urandom),
                              CH_W'($urandom), CH_W'($urandom));
                end
            end else begin
                send_word(CMD_W'($urandom), ROW_W'($urandom), CH_W'($urandom),
                          CH_W'($urandom), CH_W'($urandom));
            end
        end
    endtask

    task automatic test_random_phases();
        set_regs($urandom_range(1, 2048), $urandom_range(1, 5), $urandom_range(1, 22050), 10);
        set_idling(0, 0);
        run_random(40);
        set_idling(69, 0);
        run_random(40);
        // hold the sender until every sample has come back
        drain_core();
        set_idling(0, 69);
        run_random(40);
        set_regs($urandom_range(1, 64), $urandom_range(2, 9), $urandom_range(1, 500),
                 $urandom_range(0, 255));
        set_idling(18, 18);
        run_random(40);
        set_regs(2048, 8820, 22000, 10);
        set_idling(0, 0);
        run_random(30);
    endtask

    initial begin
        build_luts();
        cfg_height = RST_HEIGHT;
        cfg_spc = RST_SPC;
        cfg_top = RST_TOP;
        cfg_thr = RST_THR;
        bank_count = 0;
        column_pos = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_dense_column();
        test_random_phases();
        drain_core();
        if (error_count == 0) $display("image_column_additive_synth_core regression: pass");
        else $display("image_column_additive_synth_core regression: fail");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("image_column_additive_synth_core regression: fail");
        $finish;
    end

endmodule
